// File: hw/rtl/whole_word_replace_stream_assert.svh
`ifndef WHOLE_WORD_REPLACE_STREAM_ASSERT_SVH
`define WHOLE_WORD_REPLACE_STREAM_ASSERT_SVH

// Check a condition at every clock edge outside reset
`define WWR_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle
`define WWR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/wwr_pkg.sv
package wwr_pkg;

  // Window holds a full pattern prefix plus the incoming character
  localparam int unsigned HELD = 16;
  localparam int unsigned WIN  = HELD + 1;

  // Configuration register indexes
  localparam logic [2:0] CFG_OLD_LO = 3'd0;
  localparam logic [2:0] CFG_OLD_HI = 3'd1;
  localparam logic [2:0] CFG_OLD_LEN = 3'd2;
  localparam logic [2:0] CFG_NEW_LO = 3'd3;
  localparam logic [2:0] CFG_NEW_HI = 3'd4;
  localparam logic [2:0] CFG_NEW_LEN = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAKE,
    S_RESCAN,
    S_EMIT,
    S_FIN,
    S_DRAIN,
    S_FLUSH
  } state_e;

  typedef enum logic {
    SRC_PAT,
    SRC_REP
  } src_e;

  typedef logic [WIN-1:0][7:0] win_t;

  typedef struct packed {
    logic       take_hit;
    logic       prefix_ok;
    logic [7:0] last_pat;
    logic [7:0] pat_byte;
    logic [7:0] rep_byte;
  } match_t;

  function automatic logic is_word(input logic [7:0] c);
    is_word = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
              (c >= 8'h30 && c <= 8'h39) || (c == 8'h5f);
  endfunction

endpackage

// File: hw/rtl/wwr_match.sv
module wwr_match (
  input  logic [63:0]         pat_lo_i,
  input  logic [63:0]         pat_hi_i,
  input  logic [63:0]         rep_lo_i,
  input  logic [63:0]         rep_hi_i,
  input  logic [4:0]          pat_len_i,
  input  wwr_pkg::win_t       win_i,
  input  logic [4:0]          cnt_i,
  input  logic [7:0]          char_i,
  input  logic [3:0]          idx_i,
  output wwr_pkg::match_t     match_o
);
  import wwr_pkg::*;

  logic [127:0] patw;
  logic [127:0] repw;
  logic [4:0]   rem;
  logic [3:0]   last_idx;
  logic [HELD-1:0] lane_ok;

  assign patw = {pat_hi_i, pat_lo_i};
  assign repw = {rep_hi_i, rep_lo_i};
  assign last_idx = 4'(pat_len_i - 5'd1);

  // Count left after dropping the front character
  assign rem = (cnt_i == 5'd0) ? 5'd0 : cnt_i - 5'd1;

  // Compare the shifted window against the pattern, lane by lane
  always_comb begin
    for (int i = 0; i < HELD; i++) begin
      lane_ok[i] = (5'(i) >= rem) || (win_i[i+1] == patw[8*i +: 8]);
    end
  end

  always_comb begin
    match_o.take_hit  = (cnt_i < pat_len_i) && (char_i == patw[8*cnt_i[3:0] +: 8]);
    match_o.prefix_ok = (rem <= pat_len_i) && (&lane_ok);
    match_o.last_pat  = patw[8*last_idx +: 8];
    match_o.pat_byte  = patw[8*idx_i +: 8];
    match_o.rep_byte  = repw[8*idx_i +: 8];
  end

endmodule

// File: hw/rtl/whole_word_replace_stream.sv
// Channel  | Direction | tdata        | tuser        | tlast
// s_axis   | in        | in_char      | in_valid     | in_last
// m_axis   | out       | out_char     | out_has_char | out_last
// cfg      | in        | cfg_data_i, register at cfg_index_i (0..5)
//
// Input is taken only at idle, so an item is through before the next is taken:
// a rescan after a mismatch drops window characters one at a time, a
// replacement or pattern copy emits its characters, and the drain at end of
// string emits each held character.
// The single window/emit sequencer runs all of these steps.
// Reset clears the window count, match flags and output stage; the window
// bytes hold garbage until written. Output stalls hold the sequencer.
module whole_word_replace_stream #(
  parameter int unsigned PATTERN_MAX = 16,
  parameter int unsigned REPLACE_MAX = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_char
  input  logic [0:0]  s_axis_tuser,   // [0] in_valid
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_char
  output logic [0:0]  m_axis_tuser,   // [0] out_has_char
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import wwr_pkg::*;

  localparam int unsigned PLIM = (PATTERN_MAX < HELD) ? PATTERN_MAX : HELD;
  localparam int unsigned RLIM = (REPLACE_MAX < HELD) ? REPLACE_MAX : HELD;

  logic [63:0] old_lo_q, old_hi_q, new_lo_q, new_hi_q;
  logic [4:0]  old_len_q, new_len_q;
  logic [4:0]  pat_len, rep_len;

  state_e      state_q, state_d, ret_q, ret_d;
  src_e        src_q, src_d;
  logic [4:0]  idx_q, idx_d, n_q, n_d;
  logic [7:0]  c_q, c_d;
  logic        vld_q, vld_d, last_q, last_d;
  win_t        win_q, win_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        mc_q, mc_d, biw_q, biw_d;
  logic        stg_v_q, stg_v_d;
  logic [7:0]  stg_c_q, stg_c_d;
  logic        out_v_q, out_v_d, out_h_q, out_h_d, out_l_q, out_l_d;
  logic [7:0]  out_c_q, out_c_d;

  match_t      match;
  logic        s_fire, out_free, emit_ok, emit_en;
  logic [7:0]  emit_c;
  logic [7:0]  emit_byte;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_v_q || m_axis_tready;
  assign emit_ok       = !stg_v_q || out_free;

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_c_q;
  assign m_axis_tuser  = out_h_q;
  assign m_axis_tlast  = out_l_q;

  // Clamp configured lengths
  always_comb begin
    if (old_len_q == 5'd0) begin
      pat_len = 5'd1;
    end else if (old_len_q > 5'(PLIM)) begin
      pat_len = 5'(PLIM);
    end else begin
      pat_len = old_len_q;
    end
    rep_len = (new_len_q > 5'(RLIM)) ? 5'(RLIM) : new_len_q;
  end

  wwr_match u_match (
    .pat_lo_i  (old_lo_q),
    .pat_hi_i  (old_hi_q),
    .rep_lo_i  (new_lo_q),
    .rep_hi_i  (new_hi_q),
    .pat_len_i (pat_len),
    .win_i     (win_q),
    .cnt_i     (cnt_q),
    .char_i    (c_q),
    .idx_i     (idx_q[3:0]),
    .match_o   (match)
  );

  assign emit_byte = (src_q == SRC_PAT) ? match.pat_byte : match.rep_byte;

  // Next state
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          if (!s_axis_tuser[0]) begin
            state_d = S_FIN;
          end else if (mc_q) begin
            state_d = S_EMIT;
            ret_d   = S_TAKE;
          end else begin
            state_d = S_TAKE;
          end
        end
      end
      S_TAKE: begin
        if (!match.take_hit) begin
          state_d = S_RESCAN;
        end else if ((cnt_q + 5'd1 == pat_len) && biw_q) begin
          state_d = S_EMIT;
          ret_d   = S_FIN;
        end else begin
          state_d = S_FIN;
        end
      end
      S_RESCAN: begin
        if (emit_ok && match.prefix_ok) state_d = S_FIN;
      end
      S_EMIT: begin
        if (idx_q >= n_q) state_d = ret_q;
      end
      S_FIN: begin
        if (!last_q) begin
          state_d = S_FLUSH;
        end else if (mc_q) begin
          state_d = S_EMIT;
          ret_d   = S_FLUSH;
        end else begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (cnt_q == 5'd0) state_d = S_FLUSH;
      end
      S_FLUSH: begin
        if (out_free || !(stg_v_q || last_q)) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and emit control
  always_comb begin
    src_d   = src_q;
    idx_d   = idx_q;
    n_d     = n_q;
    c_d     = c_q;
    vld_d   = vld_q;
    last_d  = last_q;
    win_d   = win_q;
    cnt_d   = cnt_q;
    mc_d    = mc_q;
    biw_d   = biw_q;
    emit_en = 1'b0;
    emit_c  = win_q[0];
    out_v_d = out_v_q && !m_axis_tready;
    out_c_d = out_c_q;
    out_h_d = out_h_q;
    out_l_d = out_l_q;
    stg_v_d = stg_v_q;
    stg_c_d = stg_c_q;

    unique case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          c_d    = s_axis_tdata;
          vld_d  = s_axis_tuser[0];
          last_d = s_axis_tlast;
          if (s_axis_tuser[0] && mc_q) begin
            // Settle the held match on its right neighbor
            src_d = is_word(s_axis_tdata) ? SRC_PAT : SRC_REP;
            n_d   = is_word(s_axis_tdata) ? pat_len : rep_len;
            idx_d = 5'd0;
            cnt_d = 5'd0;
            mc_d  = 1'b0;
            biw_d = is_word(match.last_pat);
          end
        end
      end
      S_TAKE: begin
        win_d[cnt_q] = c_q;
        cnt_d        = cnt_q + 5'd1;
        if (match.take_hit && (cnt_q + 5'd1 == pat_len)) begin
          if (biw_q) begin
            // Left neighbor is a word character: copy pattern unchanged
            src_d = SRC_PAT;
            n_d   = pat_len;
            idx_d = 5'd0;
            cnt_d = 5'd0;
            biw_d = is_word(match.last_pat);
          end else begin
            mc_d = 1'b1;
          end
        end
      end
      S_RESCAN: begin
        if (emit_ok) begin
          emit_en = 1'b1;
          biw_d   = is_word(win_q[0]);
          win_d   = win_t'(win_q >> 8);
          cnt_d   = cnt_q - 5'd1;
        end
      end
      S_EMIT: begin
        if (idx_q < n_q && emit_ok) begin
          emit_en = 1'b1;
          emit_c  = emit_byte;
          idx_d   = idx_q + 5'd1;
        end
      end
      S_FIN: begin
        if (last_q && mc_q) begin
          src_d = SRC_REP;
          n_d   = rep_len;
          idx_d = 5'd0;
        end
      end
      S_DRAIN: begin
        if (cnt_q != 5'd0 && emit_ok) begin
          emit_en = 1'b1;
          win_d   = win_t'(win_q >> 8);
          cnt_d   = cnt_q - 5'd1;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          if (stg_v_q) begin
            out_v_d = 1'b1;
            out_c_d = stg_c_q;
            out_h_d = 1'b1;
            out_l_d = last_q;
            stg_v_d = 1'b0;
          end else if (last_q) begin
            out_v_d = 1'b1;
            out_c_d = 8'd0;
            out_h_d = 1'b0;
            out_l_d = 1'b1;
          end
        end
        if (last_q && (out_free || !(stg_v_q || last_q))) begin
          cnt_d = 5'd0;
          mc_d  = 1'b0;
          biw_d = 1'b0;
        end
      end
      default: ;
    endcase

    // Push the staged item out and stage the new one
    if (emit_en) begin
      if (stg_v_q) begin
        out_v_d = 1'b1;
        out_c_d = stg_c_q;
        out_h_d = 1'b1;
        out_l_d = 1'b0;
      end
      stg_v_d = 1'b1;
      stg_c_d = emit_c;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      old_lo_q  <= '0;
      old_hi_q  <= '0;
      old_len_q <= 5'd1;
      new_lo_q  <= '0;
      new_hi_q  <= '0;
      new_len_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_OLD_LO:  old_lo_q  <= cfg_data_i;
        CFG_OLD_HI:  old_hi_q  <= cfg_data_i;
        CFG_OLD_LEN: old_len_q <= cfg_data_i[4:0];
        CFG_NEW_LO:  new_lo_q  <= cfg_data_i;
        CFG_NEW_HI:  new_hi_q  <= cfg_data_i;
        CFG_NEW_LEN: new_len_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      cnt_q   <= '0;
      mc_q    <= 1'b0;
      biw_q   <= 1'b0;
      stg_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      cnt_q   <= cnt_d;
      mc_q    <= mc_d;
      biw_q   <= biw_d;
      stg_v_q <= stg_v_d;
      out_v_q <= out_v_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    src_q   <= src_d;
    idx_q   <= idx_d;
    n_q     <= n_d;
    c_q     <= c_d;
    vld_q   <= vld_d;
    last_q  <= last_d;
    win_q   <= win_d;
    stg_c_q <= stg_c_d;
    out_c_q <= out_c_d;
    out_h_q <= out_h_d;
    out_l_q <= out_l_d;
  end

`include "whole_word_replace_stream_assert.svh"

  `WWR_ASSERT_IMP(a_idle_no_stage, state_q == S_IDLE, !stg_v_q, "staged item left at idle")
  `WWR_ASSERT_IMP(a_idle_cnt, state_q == S_IDLE, cnt_q <= 5'd16, "window count overflow")
  `WWR_ASSERT_IMP(a_rescan_no_match, state_q == S_RESCAN, !mc_q && cnt_q != 5'd0,
                  "rescan with held match or empty window")
  `WWR_ASSERT_IMP(a_take_valid, state_q == S_TAKE, vld_q, "take without a character")

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import wwr_pkg::*;

  localparam int unsigned LIMIT     = 1000000;
  localparam int unsigned MAX_OUT   = 34;
  localparam int unsigned SETTLE    = 200;

  typedef struct {
    logic [7:0] ch;
    logic       has;
    logic       last;
  } out_char_t;

  // Whole-word replace predictor and queue of expected output characters
  class replace_scoreboard;
    logic [63:0] pat_lo, pat_hi, rep_lo, rep_hi;
    logic [4:0]  pat_len_reg, rep_len_reg;
    logic [7:0]  held [HELD];
    int unsigned held_n;
    bit          full_match, left_word;
    int unsigned step_n;
    int unsigned errors;
    out_char_t   expected [$];

    function new();
      pat_lo = '0; pat_hi = '0; rep_lo = '0; rep_hi = '0;
      pat_len_reg = 5'd1; rep_len_reg = 5'd0;
      held_n = 0; full_match = 0; left_word = 0; errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] val);
      case (idx)
        CFG_OLD_LO:  pat_lo = val;
        CFG_OLD_HI:  pat_hi = val;
        CFG_OLD_LEN: pat_len_reg = val[4:0];
        CFG_NEW_LO:  rep_lo = val;
        CFG_NEW_HI:  rep_hi = val;
        CFG_NEW_LEN: rep_len_reg = val[4:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] pick(logic [63:0] lo, logic [63:0] hi, int unsigned i);
      return (i < 8) ? lo[8*i +: 8] : hi[8*(i-8) +: 8];
    endfunction

    function int unsigned pattern_len();
      int unsigned v;
      v = pat_len_reg;
      if (v < 1) v = 1;
      if (v > HELD) v = HELD;
      return v;
    endfunction

    function int unsigned replace_len();
      int unsigned v;
      v = rep_len_reg;
      if (v > HELD) v = HELD;
      return v;
    endfunction

    function bit word_char(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
             (c >= "0" && c <= "9") || c == "_";
    endfunction

    function void push(logic [7:0] c);
      if (step_n >= MAX_OUT) return;
      expected.push_back('{c, 1'b1, 1'b0});
      step_n++;
    endfunction

    function void push_pattern();
      for (int unsigned i = 0; i < pattern_len(); i++) push(pick(pat_lo, pat_hi, i));
    endfunction

    function void push_replacement();
      for (int unsigned i = 0; i < replace_len(); i++) push(pick(rep_lo, rep_hi, i));
    endfunction

    function void close_match();
      held_n = 0;
      full_match = 0;
      left_word = word_char(pick(pat_lo, pat_hi, pattern_len() - 1));
    endfunction

    // Consume one character: settle a held match, then extend the held prefix or emit from its front
    function void take(logic [7:0] c);
      logic [7:0] win [WIN];
      int unsigned n, start;
      bit ok;
      if (full_match) begin
        if (word_char(c)) push_pattern();
        else push_replacement();
        close_match();
      end
      if (held_n < pattern_len() && c == pick(pat_lo, pat_hi, held_n)) begin
        held[held_n] = c;
        held_n++;
        if (held_n == pattern_len()) begin
          if (left_word) begin
            push_pattern();
            close_match();
          end else begin
            full_match = 1;
          end
        end
      end else begin
        n = held_n;
        for (int unsigned i = 0; i < n; i++) win[i] = held[i];
        win[n] = c;
        n++;
        start = 0;
        do begin
          push(win[start]);
          left_word = word_char(win[start]);
          start++;
          ok = (n - start) <= pattern_len();
          for (int unsigned i = 0; ok && i < n - start; i++)
            if (win[start+i] != pick(pat_lo, pat_hi, i)) ok = 0;
        end while (!ok);
        held_n = n - start;
        for (int unsigned i = 0; i < held_n; i++) held[i] = win[start+i];
      end
    endfunction

    function void note_item(logic [7:0] c, bit v, bit l);
      step_n = 0;
      if (v) take(c);
      if (l) begin
        if (full_match) push_replacement();
        else for (int unsigned i = 0; i < held_n; i++) push(held[i]);
        if (step_n == 0) expected.push_back('{8'h00, 1'b0, 1'b1});
        else expected[expected.size()-1].last = 1'b1;
        held_n = 0;
        full_match = 0;
        left_word = 0;
      end
    endfunction

    function void check_result(logic [7:0] c, logic h, logic l);
      out_char_t e;
      if (expected.size() == 0) begin
        $display("%0t: unexpected output char=%h has=%b last=%b", $time, c, h, l);
        errors++;
        return;
      end
      e = expected.pop_front();
      if (c !== e.ch || h !== e.has || l !== e.last) begin
        $display("%0t: mismatch expected char=%h has=%b last=%b, got char=%h has=%b last=%b",
                 $time, e.ch, e.has, e.last, c, h, l);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid, m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i, cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [63:0] cfg_data_i;

  replace_scoreboard sb = new();
  bit           quiet;
  bit           long_hold_req;
  logic [127:0] cur_pat;
  int unsigned  cur_len;
  int unsigned  cycles;

  whole_word_replace_stream i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Output side: check each item, stall at random, hold off on request
  initial begin
    int unsigned hold_n;
    hold_n = 0;
    m_axis_tready = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
      if (long_hold_req && hold_n == 0) begin
        hold_n = 400;
        long_hold_req = 0;
      end else if (!quiet && hold_n == 0 && $urandom_range(0, 59) == 0) begin
        hold_n = $urandom_range(10, 50);
      end
      if (hold_n > 0) begin
        hold_n--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet ? 1'b1 : ($urandom_range(0, 4) != 0);
      end
    end
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 70) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(logic [7:0] c, bit v, bit l);
    int unsigned gap;
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid   <= 1'b1;
    s_axis_tdata    <= c;
    s_axis_tuser[0] <= v;
    s_axis_tlast    <= l;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_item(c, v, l);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, val);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drain all expected output, then let a silent item finish
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic configure(logic [127:0] pat, int unsigned plen,
                           logic [127:0] rep, int unsigned rlen);
    write_reg(CFG_OLD_LO, pat[63:0]);
    write_reg(CFG_OLD_HI, pat[127:64]);
    write_reg(CFG_OLD_LEN, 64'(plen));
    write_reg(CFG_NEW_LO, rep[63:0]);
    write_reg(CFG_NEW_HI, rep[127:64]);
    write_reg(CFG_NEW_LEN, 64'(rlen));
    cur_pat = pat;
    cur_len = plen;
  endtask

  function automatic logic [7:0] alpha_char();
    case ($urandom_range(0, 7))
      0: return "a";
      1: return "b";
      2: return "_";
      3: return "7";
      4: return " ";
      5: return ".";
      6: return "Z";
      default: return 8'($urandom);
    endcase
  endfunction

  // Random pattern mostly from the small alphabet (high bytes become "a"), unused bytes random
  function automatic logic [127:0] rand_text(int unsigned n);
    logic [127:0] t;
    t = {$urandom, $urandom, $urandom, $urandom};
    for (int unsigned i = 0; i < n; i++) begin
      t[8*i +: 8] = alpha_char();
      if (t[8*i +: 8] > 8'h7f) t[8*i +: 8] = "a";
    end
    return t;
  endfunction

  // Strings mixing whole and partial pattern copies with separators
  task automatic run_strings(int unsigned n_items);
    logic [7:0] s [$];
    int unsigned sent, k, len, r;
    sent = 0;
    while (sent < n_items) begin
      s.delete();
      len = $urandom_range(0, 10);
      while (s.size() < len) begin
        r = $urandom_range(0, 9);
        if (r < 3) begin
          k = (r == 0) ? $urandom_range(1, cur_len) : cur_len;
          for (int unsigned i = 0; i < k; i++) s.push_back(cur_pat[8*i +: 8]);
        end else begin
          s.push_back(alpha_char());
        end
      end
      r = $urandom_range(0, 9);
      foreach (s[i]) begin
        if ($urandom_range(0, 19) == 0) send_item(8'($urandom), 1'b0, 1'b0);
        send_item(s[i], 1'b1, (i == s.size() - 1) && r != 0);
        sent++;
      end
      if (r == 0 || s.size() == 0) begin
        send_item(8'($urandom), 1'b0, 1'b1);
        sent++;
      end
    end
  endtask

  task automatic send_text(string t, bit l);
    for (int i = 0; i < t.len(); i++) send_item(t[i], 1'b1, l && i == t.len() - 1);
  endtask

  initial begin
    int unsigned plen;
    s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = '0; s_axis_tlast = 0;
    cfg_valid_i = 0; cfg_index_i = '0; cfg_data_i = '0;
    quiet = 0; long_hold_req = 0;
    cur_pat = '0; cur_len = 1;
    rst_ni = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: boundaries on both sides, end of string, empty and silent items
    configure({104'h0, "tac"}, 3, {104'h0, "god"}, 3);
    send_text("cat", 1);
    send_text(" cat.", 1);
    send_text("xcat ", 1);
    send_text("cats", 1);
    send_text("ca", 1);
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b1);
    wait_idle();

    // Single-character pattern deleted
    configure(rand_text(1), 1, {$urandom, $urandom, $urandom, $urandom}, 0);
    run_strings(50);
    wait_idle();

    // Longest pattern and replacement, receiver held off while input fills
    configure(rand_text(16), 16, {$urandom, $urandom, $urandom, $urandom}, 16);
    long_hold_req = 1;
    run_strings(60);
    wait_idle();

    quiet = 1;
    configure(rand_text(2), 2, rand_text(5), 5);
    run_strings(40);
    wait_idle();
    quiet = 0;

    for (int p = 0; p < 5; p++) begin
      plen = $urandom_range(1, 5);
      configure(rand_text(plen), plen, rand_text(16), $urandom_range(0, 16));
      run_strings(45);
      wait_idle();
    end

    if (sb.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
